// ----- hdl/slcr_pkg.sv -----
// Package of the serial line command recognizer: command and status codes,
// command texts and lengths, character constants and matching helpers.
// Depends on nothing; imported by serial_line_command_recognizer.
`default_nettype none

package slcr_pkg;

  // line length at which any further byte overflows the line, and the width of the character count
  localparam int unsigned LINE_MAX     = 256;
  localparam int unsigned CNT_W        = $clog2(LINE_MAX + 1);
  localparam int unsigned CMD_COUNT    = 5;
  localparam int unsigned CMD_TEXT_LEN = 10;
  localparam int unsigned CMD_POS_W    = $clog2(CMD_TEXT_LEN);
  localparam int unsigned CMD_LEN_W    = $clog2(CMD_TEXT_LEN + 1);

  // character codes
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam logic [CMD_COUNT-1:0] ALL_CANDIDATES = '1;

  typedef enum logic [2:0] {
    CMD_HELP    = 3'd0,
    CMD_LED_ON  = 3'd1,
    CMD_LED_OFF = 3'd2,
    CMD_TOGGLE  = 3'd3,
    CMD_STATUS  = 3'd4,
    CMD_NONE    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COMMENT  = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // command texts, padded with zero past their length
  localparam logic [7:0] CMD_TEXT [CMD_COUNT][CMD_TEXT_LEN] = '{
    '{8'h48, 8'h45, 8'h4C, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4C, 8'h45, 8'h44, 8'h20, 8'h4F, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4C, 8'h45, 8'h44, 8'h20, 8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00},
    '{8'h4C, 8'h45, 8'h44, 8'h20, 8'h54, 8'h4F, 8'h47, 8'h47, 8'h4C, 8'h45},
    '{8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [CMD_LEN_W-1:0] CMD_LEN [CMD_COUNT] = '{
    CMD_LEN_W'(4), CMD_LEN_W'(6), CMD_LEN_W'(7), CMD_LEN_W'(10), CMD_LEN_W'(6)
  };

  // carriage return or line feed
  function automatic logic is_terminator(input logic [7:0] b);
    return (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

  // fold a..z to upper case
  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    if ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) begin
      return b - CASE_OFFSET;
    end
    return b;
  endfunction

  // candidates whose character at position pos equals the folded byte
  function automatic logic [CMD_COUNT-1:0] char_hits(input logic [CNT_W-1:0] pos,
                                                     input logic [7:0]       b);
    logic [7:0]           u;
    logic [CMD_POS_W-1:0] idx;
    logic                 in_text;
    logic [CMD_COUNT-1:0] hits;
    u       = fold_upper(b);
    in_text = (pos < CNT_W'(CMD_TEXT_LEN));
    idx     = in_text ? pos[CMD_POS_W-1:0] : '0;
    for (int k = 0; k < CMD_COUNT; k++) begin
      hits[k] = in_text && (pos < CNT_W'(CMD_LEN[k])) && (CMD_TEXT[k][idx] == u);
    end
    return hits;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/serial_line_command_recognizer.sv -----
// Serial line command recognizer: byte-wise line matcher with LED state and
// a one-entry result register. Depends on slcr_pkg.
`default_nettype none

// Usage
//   rx channel (rx_valid_i / rx_ready_o / rx_byte_i) takes one received byte
//   per request. A line is ended by CR or LF; CR and LF between lines are
//   dropped. The cmd channel (cmd_valid_o / cmd_ready_i) gives one request
//   per finished line: command_o, line_status_o and led_level_o.
// Latency and throughput
//   one byte per cycle while no result waits with cmd_ready_i low; the result
//   of a line is valid in the cycle after its terminator (or its overflowing
//   byte) is taken. All matching is done in the cycle a byte is taken,
//   between the byte port and the state and result registers.
// Reset
//   rst_ni clears to idle with no pending result and the LED off.
// Stall
//   a result waits in the output register; while it waits with cmd_ready_i
//   low, rx_ready_o is low for every byte, so no byte is taken until the
//   pending result is taken (a byte can be taken in that same cycle).
module serial_line_command_recognizer
  import slcr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output logic [2:0]      command_o,
  output logic [1:0]      line_status_o,
  output logic            led_level_o
);

  logic                 in_line_q, in_line_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CMD_COUNT-1:0] mask_q, mask_d;
  logic                 comment_q, comment_d;
  logic                 slash_q, slash_d;
  logic                 led_q, led_d;
  logic                 out_valid_q, out_valid_d;
  cmd_e                 out_cmd_q, out_cmd_d;
  status_e              out_st_q, out_st_d;
  logic                 out_led_q;

  logic                 accept;
  logic                 emit;
  logic                 term;
  logic [CMD_COUNT-1:0] len_hit;
  logic [CMD_COUNT-1:0] full_hit;
  logic                 any_hit;
  cmd_e                 hit_cmd;

  // byte is taken while the result register is free or being drained
  assign rx_ready_o = !out_valid_q || cmd_ready_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign term       = is_terminator(rx_byte_i);

  // candidates whose length equals the line length, lowest code wins
  always_comb begin
    hit_cmd = CMD_NONE;
    for (int k = 0; k < CMD_COUNT; k++) begin
      len_hit[k] = (count_q == CNT_W'(CMD_LEN[k]));
    end
    full_hit = mask_q & len_hit;
    any_hit  = |full_hit;
    for (int k = CMD_COUNT - 1; k >= 0; k--) begin
      if (full_hit[k]) begin
        hit_cmd = cmd_e'(3'(k));
      end
    end
  end

  // line state and result selection
  always_comb begin
    in_line_d = in_line_q;
    count_d   = count_q;
    mask_d    = mask_q;
    comment_d = comment_q;
    slash_d   = slash_q;
    led_d     = led_q;
    emit      = 1'b0;
    out_cmd_d = CMD_NONE;
    out_st_d  = ST_OK;
    if (accept) begin
      if (!in_line_q) begin
        if (!term) begin
          in_line_d = 1'b1;
          mask_d    = char_hits('0, rx_byte_i);
          comment_d = (rx_byte_i == CHAR_HASH);
          slash_d   = (rx_byte_i == CHAR_SLASH);
          count_d   = CNT_W'(1);
        end
      end else if ((count_q >= CNT_W'(LINE_MAX)) || term) begin
        emit = 1'b1;
        if (count_q >= CNT_W'(LINE_MAX)) begin
          out_st_d = ST_OVERFLOW;
        end else if (comment_q) begin
          out_st_d = ST_COMMENT;
        end else if (any_hit) begin
          out_cmd_d = hit_cmd;
          unique case (hit_cmd)
            CMD_LED_ON:  led_d = 1'b1;
            CMD_LED_OFF: led_d = 1'b0;
            CMD_TOGGLE:  led_d = !led_q;
            default:     led_d = led_q;
          endcase
        end else begin
          out_st_d = ST_UNKNOWN;
        end
        // back to idle
        in_line_d = 1'b0;
        count_d   = '0;
        mask_d    = ALL_CANDIDATES;
        comment_d = 1'b0;
        slash_d   = 1'b0;
      end else begin
        if ((count_q == CNT_W'(1)) && slash_q && (rx_byte_i == CHAR_SLASH)) begin
          comment_d = 1'b1;
        end
        mask_d  = mask_q & char_hits(count_q, rx_byte_i);
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  // result register valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_line_q   <= 1'b0;
      count_q     <= '0;
      mask_q      <= ALL_CANDIDATES;
      comment_q   <= 1'b0;
      slash_q     <= 1'b0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_line_q   <= in_line_d;
      count_q     <= count_d;
      mask_q      <= mask_d;
      comment_q   <= comment_d;
      slash_q     <= slash_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_cmd_q <= out_cmd_d;
      out_st_q  <= out_st_d;
      out_led_q <= led_d;
    end
  end

  assign cmd_valid_o   = out_valid_q;
  assign command_o     = out_cmd_q;
  assign line_status_o = out_st_q;
  assign led_level_o   = out_led_q;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for serial_line_command_recognizer: streams text lines over the rx
// channel and checks every line verdict against a built-in line predictor.
// Depends on slcr_pkg and the recognizer RTL only.
`timescale 1ns / 100ps

module tb_top;
  import slcr_pkg::*;

  localparam int unsigned RUN_LIMIT    = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 550;
  localparam logic [7:0]  KEY_LF       = 8'h0A;
  localparam logic [7:0]  KEY_CR       = 8'h0D;
  localparam logic [7:0]  KEY_HASH     = 8'h23;
  localparam logic [7:0]  KEY_SLASH    = 8'h2F;

  typedef logic [7:0] byte_seq_t [$];

  typedef struct packed {
    cmd_e    command;
    status_e status;
    logic    led;
  } line_verdict_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       rx_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       cmd_ready_i = 1'b0;
  logic       rx_ready_o;
  logic       cmd_valid_o;
  logic [2:0] command_o;
  logic [1:0] line_status_o;
  logic       led_level_o;

  // command words in code order
  string cmd_words [5] = '{"HELP", "LED ON", "LED OFF", "LED TOGGLE", "STATUS"};

  // line tracker state
  logic       line_open;
  logic [8:0] line_len;
  logic [4:0] word_mask;
  logic       comment_line;
  logic       lead_slash;
  logic       led_state;

  line_verdict_t awaited_verdicts [$];
  int          errors        = 0;
  int          bytes_taken   = 0;
  int          lines_checked = 0;
  int          status_tally [4];
  int          cycles        = 0;
  int          stall_left    = 0;
  bit          steady        = 1'b0;
  bit          rx_held       = 1'b0;

  serial_line_command_recognizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .cmd_valid_o  (cmd_valid_o),
    .cmd_ready_i  (cmd_ready_i),
    .command_o    (command_o),
    .line_status_o(line_status_o),
    .led_level_o  (led_level_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("%0t: timeout, %0d verdicts still awaited", $time, awaited_verdicts.size());
      $display("status: fail");
      $finish;
    end
  end

  // mostly no idle gap, some short ones, a few long ones, none in steady stretches
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // command words whose character at position pos matches the folded byte
  function automatic logic [4:0] letter_hits(int pos, logic [7:0] b);
    logic [7:0] up;
    logic [4:0] hits;
    up = ((b >= 8'h61) && (b <= 8'h7A)) ? b - 8'd32 : b;
    for (int k = 0; k < 5; k++) begin
      hits[k] = (pos < cmd_words[k].len()) && (8'(cmd_words[k][pos]) == up);
    end
    return hits;
  endfunction

  // queue the verdict of a finished line and go idle
  function automatic void close_line(cmd_e c, status_e s);
    line_verdict_t v;
    v = '{command: c, status: s, led: led_state};
    awaited_verdicts.push_back(v);
    line_open    = 1'b0;
    line_len     = '0;
    word_mask    = '1;
    comment_line = 1'b0;
    lead_slash   = 1'b0;
  endfunction

  // advance the line tracker by one taken byte; returns 1 if the byte was ignored
  function automatic bit advance_line(logic [7:0] b);
    bit found;
    found = 1'b0;
    if (!line_open) begin
      if ((b == KEY_LF) || (b == KEY_CR)) return 1'b1;
      line_open    = 1'b1;
      word_mask    = letter_hits(0, b);
      comment_line = (b == KEY_HASH);
      lead_slash   = (b == KEY_SLASH);
      line_len     = 9'd1;
      return 1'b0;
    end
    // a full line overflows on any further byte, which is dropped
    if (line_len >= LINE_MAX) begin
      close_line(CMD_NONE, ST_OVERFLOW);
      return 1'b0;
    end
    if ((b == KEY_LF) || (b == KEY_CR)) begin
      if (comment_line) begin
        close_line(CMD_NONE, ST_COMMENT);
        return 1'b0;
      end
      for (int k = 0; k < 5; k++) begin
        if (!found && word_mask[k] && (int'(line_len) == cmd_words[k].len())) begin
          found = 1'b1;
          case (cmd_e'(k))
            CMD_LED_ON:  led_state = 1'b1;
            CMD_LED_OFF: led_state = 1'b0;
            CMD_TOGGLE:  led_state = !led_state;
            default:     led_state = led_state;
          endcase
          close_line(cmd_e'(k), ST_OK);
        end
      end
      if (!found) close_line(CMD_NONE, ST_UNKNOWN);
      return 1'b0;
    end
    if ((line_len == 9'd1) && lead_slash && (b == KEY_SLASH)) comment_line = 1'b1;
    word_mask = word_mask & letter_hits(int'(line_len), b);
    line_len  = line_len + 9'd1;
    return 1'b0;
  endfunction

  // verdict checker
  always @(posedge clk_i) begin
    line_verdict_t want;
    if (rst_ni && cmd_valid_o && cmd_ready_i) begin
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: verdict with none expected: command %0d status %0d led %0b",
                 $time, command_o, line_status_o, led_level_o);
        errors++;
      end else begin
        want = awaited_verdicts.pop_front();
        lines_checked++;
        status_tally[want.status]++;
        if (command_o !== want.command) begin
          $display("%0t: command expected %0d actual %0d", $time, want.command, command_o);
          errors++;
        end
        if (line_status_o !== want.status) begin
          $display("%0t: line_status expected %0d actual %0d",
                   $time, want.status, line_status_o);
          errors++;
        end
        if (led_level_o !== want.led) begin
          $display("%0t: led_level expected %0b actual %0b", $time, want.led, led_level_o);
          errors++;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      cmd_ready_i <= 1'b0;
    end else begin
      cmd_ready_i <= 1'b1;
      if (!steady && ($urandom_range(0, 99) < 25)) begin
        stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 30);
      end
    end
  end

  // drop rx valid if a request is still held up
  task automatic rx_release();
    if (rx_held) begin
      rx_valid_i <= 1'b0;
      rx_held = 1'b0;
    end
  endtask

  // send one byte as a request and track it once taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      rx_release();
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    rx_held = 1'b1;
    do @(posedge clk_i); while (!rx_ready_o);
    if (!advance_line(b)) bytes_taken++;
  endtask

  task automatic send_seq(byte_seq_t s, logic [7:0] term);
    foreach (s[i]) send_byte(s[i]);
    send_byte(term);
  endtask

  function automatic byte_seq_t text_of(string s);
    byte_seq_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(8'(s[i]));
    return q;
  endfunction

  task automatic send_text(string s, logic [7:0] term);
    send_seq(text_of(s), term);
  endtask

  function automatic byte_seq_t printable(int n);
    byte_seq_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    return q;
  endfunction

  function automatic logic [7:0] any_term();
    return $urandom_range(0, 1) ? KEY_CR : KEY_LF;
  endfunction

  // sender holds off until every verdict has come back
  task automatic wait_for_results();
    rx_release();
    do @(posedge clk_i); while (awaited_verdicts.size() != 0);
  endtask

  // terminators between lines are dropped
  task automatic test_idle_terminators();
    send_byte(KEY_CR);
    send_byte(KEY_LF);
    send_byte(KEY_CR);
    send_text("help", KEY_LF);
    send_byte(KEY_LF);
  endtask

  // every command, mixed case, both terminators, led walk
  task automatic test_commands();
    send_text("HELP", KEY_CR);
    send_text("led on", KEY_LF);
    send_text("Led Off", KEY_CR);
    send_text("LED TOGGLE", KEY_LF);
    send_text("led toggle", KEY_CR);
    send_text("LeD tOgGlE", KEY_CR);
    send_text("status", KEY_LF);
    send_text("LED OFF", KEY_LF);
  endtask

  // hash and double slash lines, lone slash is plain text
  task automatic test_comments();
    send_text("#", KEY_CR);
    send_text("//", KEY_LF);
    send_text("#LED ON", KEY_CR);
    send_text("// help", KEY_LF);
    send_text("/", KEY_CR);
    send_text("/x//", KEY_LF);
    send_text("x#", KEY_CR);
  endtask

  // near misses, zero bytes, bytes next to the folding range
  task automatic test_unknown_text();
    send_text("HELPX", KEY_CR);
    send_text("HEL", KEY_LF);
    send_text("LED ONN", KEY_LF);
    send_text("LEDON", KEY_CR);
    send_text("{ELP", KEY_CR);
    send_text("`ELP", KEY_LF);
    send_seq('{8'h48, 8'h45, 8'h00, 8'h4C, 8'h50}, KEY_CR);
    send_seq('{8'h00}, KEY_LF);
    send_seq('{8'hFF, 8'h80, 8'hE8}, KEY_CR);
  endtask

  // lines at and past the length limit
  task automatic test_overflow();
    send_seq({text_of("HELP"), printable(LINE_MAX - 4)}, KEY_CR);
    send_seq(printable(LINE_MAX - 1), KEY_LF);
    send_seq({KEY_HASH, printable(LINE_MAX - 1), 8'h78}, KEY_CR);
    send_text("led on", KEY_CR);
    send_seq({text_of("LED TOGGLE"), printable(LINE_MAX - 10)}, KEY_LF);
    send_text("LED TOGGLE", KEY_LF);
  endtask

  // one random line: mostly command words, some near misses, comments and noise
  task automatic send_random_line();
    byte_seq_t  text;
    int         kind;
    int         pos;
    string      word;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    word = cmd_words[$urandom_range(0, 4)];
    if (kind < 57) begin
      for (int i = 0; i < word.len(); i++) begin
        c = 8'(word[i]);
        if ((c >= 8'h41) && (c <= 8'h5A) && $urandom_range(0, 1)) c = c + 8'd32;
        text.push_back(c);
      end
      if (kind >= 45) begin
        case ($urandom_range(0, 2))
          0: void'(text.pop_back());
          1: text.push_back(8'($urandom_range(8'h20, 8'h7E)));
          default: begin
            pos = $urandom_range(0, text.size() - 1);
            text[pos] = 8'($urandom_range(0, 255));
          end
        endcase
      end
    end else if (kind < 67) begin
      case ($urandom_range(0, 2))
        0:       text = '{KEY_HASH};
        1:       text = '{KEY_SLASH, KEY_SLASH};
        default: text = '{KEY_SLASH};
      endcase
      text = {text, printable($urandom_range(0, 8))};
    end else if (kind < 82) begin
      text = printable($urandom_range(1, 12));
    end else if (kind < 99) begin
      for (int i = $urandom_range(1, 12); i > 0; i--) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      text = printable($urandom_range(LINE_MAX - 2, LINE_MAX + 2));
    end
    if ($urandom_range(0, 9) == 0) send_byte(any_term());
    send_seq(text, any_term());
    if ($urandom_range(0, 4) == 0) send_byte(any_term());
  endtask

  // random lines with steady stretches and one full hold-off midway
  task automatic test_random_lines();
    int start;
    bit paused;
    start  = bytes_taken;
    paused = 1'b0;
    while (bytes_taken - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 24) == 0) steady = !steady;
      if (!paused && (bytes_taken - start >= RANDOM_BYTES / 2)) begin
        wait_for_results();
        paused = 1'b1;
      end
      send_random_line();
    end
    steady = 1'b0;
  endtask

  // main sequence
  initial begin
    line_open    = 1'b0;
    line_len     = '0;
    word_mask    = '1;
    comment_line = 1'b0;
    lead_slash   = 1'b0;
    led_state    = 1'b0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_terminators();
    test_commands();
    test_comments();
    test_unknown_text();
    test_overflow();
    test_random_lines();
    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d line bytes and %0d line verdicts", bytes_taken, lines_checked);
    $display("verdicts: %0d ok, %0d comment, %0d unknown, %0d overflow",
             status_tally[ST_OK], status_tally[ST_COMMENT],
             status_tally[ST_UNKNOWN], status_tally[ST_OVERFLOW]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/slcr_pkg.sv
hdl/serial_line_command_recognizer.sv
dv/tb_top.sv
